/* rtl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants for the servo frame sync scheduler.
// ----------------------------------------------------------------------------
package sfs_pkg;

   // widths of the counters and inputs
   localparam int unsigned SlowW  = 8;
   localparam int unsigned FastW  = 16;
   localparam int unsigned CntW   = 16;
   localparam int unsigned RcCntW = 17;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_HIGH_RATE_MODE   = 3'd0,
      REG_OVERDUE_LIMIT    = 3'd1,
      REG_SLOW_RC_LIMIT    = 3'd2,
      REG_LOW_RATE_PERIOD  = 3'd3,
      REG_HIGH_RATE_PERIOD = 3'd4
   } reg_index_type;

   // register values after reset
   localparam logic [CntW-1:0]   OverdueLimitRst   = 16'd9765;
   localparam logic [RcCntW-1:0] SlowRcLimitRst    = 17'd41667;
   localparam logic [CntW-1:0]   LowRatePeriodRst  = 16'd390;
   localparam logic [CntW-1:0]   HighRatePeriodRst = 16'd65;

   // result of one loop pass
   typedef struct packed {
      logic signal_lost;
      logic synced;
      logic emit_frame;
   } result_type;

endpackage

/* rtl/servo_frame_sync_scheduler.sv */
// ----------------------------------------------------------------------------
// servo_frame_sync_scheduler
// Per control-loop pass, decides whether a servo frame goes out, synced to
// the RC frame or free-running on signal loss, and flags loss of signal.
// ----------------------------------------------------------------------------
// One pass is taken per clock cycle. The tick counters and flags update at the
// edge that accepts a pass, and the result of that pass sits in an output
// register from that same edge on; a new pass is accepted whenever that register is
// empty or is being emptied in the same cycle, so a stalled result holds the
// input side for as long as it waits.
module servo_frame_sync_scheduler
   import sfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // pass input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] slow_ticks, [23:8] fast_ticks, [24] rc_frame
   // pass result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] emit_frame, [1] synced, [2] signal_lost
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic              high_rate_mode_ff;
   logic [CntW-1:0]   overdue_limit_ff;
   logic [RcCntW-1:0] slow_rc_limit_ff;
   logic [CntW-1:0]   low_rate_period_ff;
   logic [CntW-1:0]   high_rate_period_ff;

   // loop state
   logic              frame_pending_ff,  frame_pending_in;
   logic [RcCntW-1:0] rc_period_ff,      rc_period_in;
   logic [CntW-1:0]   servo_rate_ff,     servo_rate_in;
   logic [CntW-1:0]   timeout_ff,        timeout_in;
   logic              overdue_ff,        overdue_in;
   logic              servo_tick_ff,     servo_tick_in;
   logic              slow_rc_ff,        slow_rc_in;

   // output register
   logic              rsp_valid_ff,      rsp_valid_in;
   result_type        rsp_data_ff;
   result_type        result;

   // input fields
   logic [SlowW-1:0]  slow_ticks;
   logic [FastW-1:0]  fast_ticks;
   logic              rc_frame;
   logic              req_xfer;
   logic              csr_write;
   reg_index_type     csr_index;

   assign slow_ticks = req_tdata[SlowW-1:0];
   assign fast_ticks = req_tdata[SlowW +: FastW];
   assign rc_frame   = req_tdata[SlowW+FastW];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   // configuration write and readback
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         high_rate_mode_ff   <= 1'b0;
         overdue_limit_ff    <= OverdueLimitRst;
         slow_rc_limit_ff    <= SlowRcLimitRst;
         low_rate_period_ff  <= LowRatePeriodRst;
         high_rate_period_ff <= HighRatePeriodRst;
      end else if (csr_write) begin
         case (csr_index)
            REG_HIGH_RATE_MODE:   high_rate_mode_ff   <= csr_pwdata[0];
            REG_OVERDUE_LIMIT:    overdue_limit_ff    <= csr_pwdata[CntW-1:0];
            REG_SLOW_RC_LIMIT:    slow_rc_limit_ff    <= csr_pwdata[RcCntW-1:0];
            REG_LOW_RATE_PERIOD:  low_rate_period_ff  <= csr_pwdata[CntW-1:0];
            REG_HIGH_RATE_PERIOD: high_rate_period_ff <= csr_pwdata[CntW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HIGH_RATE_MODE:   csr_prdata = {31'd0, high_rate_mode_ff};
         REG_OVERDUE_LIMIT:    csr_prdata = {16'd0, overdue_limit_ff};
         REG_SLOW_RC_LIMIT:    csr_prdata = {15'd0, slow_rc_limit_ff};
         REG_LOW_RATE_PERIOD:  csr_prdata = {16'd0, low_rate_period_ff};
         REG_HIGH_RATE_PERIOD: csr_prdata = {16'd0, high_rate_period_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // one loop pass
   always_comb begin
      logic              pend;
      logic [RcCntW:0]   rc_sum;
      logic [CntW:0]     sr_sum;
      logic [CntW:0]     to_sum;
      logic [RcCntW-1:0] rc_cnt;
      logic [CntW-1:0]   sr_cnt;
      logic [CntW-1:0]   to_cnt;
      logic              ovd;
      logic              slow;
      logic              tick;
      logic [CntW-1:0]   period;

      pend   = frame_pending_ff || rc_frame;

      // saturating counter advance
      rc_sum = {1'b0, rc_period_ff} + {{(RcCntW+1-FastW){1'b0}}, fast_ticks};
      sr_sum = {1'b0, servo_rate_ff} + {{(CntW+1-SlowW){1'b0}}, slow_ticks};
      to_sum = {1'b0, timeout_ff} + {{(CntW+1-SlowW){1'b0}}, slow_ticks};
      rc_cnt = rc_sum[RcCntW] ? {RcCntW{1'b1}} : rc_sum[RcCntW-1:0];
      sr_cnt = sr_sum[CntW]   ? {CntW{1'b1}}   : sr_sum[CntW-1:0];
      to_cnt = to_sum[CntW]   ? {CntW{1'b1}}   : to_sum[CntW-1:0];

      ovd    = overdue_ff || (to_cnt > overdue_limit_ff);
      slow   = slow_rc_ff;

      // a pending frame proves the signal is alive
      if (pend) begin
         to_cnt = '0;
         ovd    = 1'b0;
         slow   = rc_cnt > slow_rc_limit_ff;
         rc_cnt = '0;
      end

      // servo rate tick
      period = high_rate_mode_ff ? high_rate_period_ff : low_rate_period_ff;
      tick   = servo_tick_ff;
      if (sr_cnt > period) begin
         tick   = 1'b1;
         sr_cnt = '0;
         // fast rc in normal mode: drop the frame to resync
         if (!high_rate_mode_ff && !slow) begin
            pend = 1'b0;
         end
      end

      // emission decision
      result = '0;
      if (pend && (slow || tick || high_rate_mode_ff)) begin
         pend              = 1'b0;
         tick              = 1'b0;
         sr_cnt            = '0;
         result.emit_frame = 1'b1;
         result.synced     = 1'b1;
      end else if (ovd && tick) begin
         tick              = 1'b0;
         sr_cnt            = '0;
         result.emit_frame = 1'b1;
      end
      result.signal_lost = ovd;

      frame_pending_in = pend;
      rc_period_in     = rc_cnt;
      servo_rate_in    = sr_cnt;
      timeout_in       = to_cnt;
      overdue_in       = ovd;
      servo_tick_in    = tick;
      slow_rc_in       = slow;
   end

   // state update on each accepted pass
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pending_ff <= 1'b0;
         rc_period_ff     <= '0;
         servo_rate_ff    <= '0;
         timeout_ff       <= '0;
         overdue_ff       <= 1'b0;
         servo_tick_ff    <= 1'b0;
         slow_rc_ff       <= 1'b0;
      end else if (req_xfer) begin
         frame_pending_ff <= frame_pending_in;
         rc_period_ff     <= rc_period_in;
         servo_rate_ff    <= servo_rate_in;
         timeout_ff       <= timeout_in;
         overdue_ff       <= overdue_in;
         servo_tick_ff    <= servo_tick_in;
         slow_rc_ff       <= slow_rc_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule
